// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/tca_pkg.sv -----
package tca_pkg;

   // Field widths.
   localparam int unsigned CELL_W  = 16;
   localparam int unsigned SPEED_W = 5;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned TOTAL_W = 15;
   localparam int unsigned CSR_IDX_W = 2;

   // Default car store depth.
   localparam int unsigned MAX_CARS_DEFAULT = 1024;

   // Register reset values.
   localparam logic [CELL_W-1:0]  TRACK_LENGTH_RST    = 16'd10000;
   localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST     = 5'd10;
   localparam logic [COUNT_W-1:0] CAR_COUNT_RST       = 11'd10;
   localparam logic [CELL_W-1:0]  BRAKE_THRESHOLD_RST = 16'd6553;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAR_COUNT       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_THRESHOLD = 2'd3;

   // Request operations.
   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [CELL_W-1:0] cell_req;
      logic [CELL_W-1:0] draw;
   } req_type;

   typedef struct packed {
      logic [TICK_W-1:0]  tick_number;
      logic [COUNT_W-1:0] laps_done;
      logic [TOTAL_W-1:0] speed_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_PLACE,
      ST_DRAW_OWN,
      ST_DRAW_GAP,
      ST_DRAW_WRAP,
      ST_ADV,
      ST_ADV_DRAIN,
      ST_EMIT
   } st_type;

endpackage

// ----- hw/rtl/traffic_cellular_automaton_step_top.sv -----
// Ring-road traffic automaton, one car per request. A placement request loads the next
// car's cell (reduced modulo the track length) with speed zero: the remainder is found
// by a restoring loop of 16 one-bit steps on the shared 18-bit adder. A draw request
// updates the next car's speed after two reads of the car store, which has one read
// port per array, and two passes through the adder for the wrapped gap. The last car's
// draw then starts a pass that moves every car, one car per cycle through the car
// store, and the summary of that pass waits for a free output register. The per-tick
// summary sits in an output register; requests are accepted again while it waits to
// be taken.
module traffic_cellular_automaton_step_top #(
   parameter int unsigned MAX_CARS = tca_pkg::MAX_CARS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tca_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tca_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tca_pkg::CELL_W-1:0]         csr_data
);
   import tca_pkg::*;

   localparam int unsigned CW = $clog2(MAX_CARS);
   localparam int unsigned NW = $clog2(MAX_CARS + 1);
   localparam int unsigned AW = CELL_W + 2;

   // Configuration registers.
   logic [CELL_W-1:0]  track_length_ff;
   logic [SPEED_W-1:0] speed_limit_ff;
   logic [COUNT_W-1:0] car_count_ff;
   logic [CELL_W-1:0]  brake_threshold_ff;

   // Control state.
   st_type             st_ff, st_in;
   logic [CW-1:0]      cursor_ff;
   logic [TICK_W-1:0]  ticks_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               pend_ff;

   // Working registers.
   logic [CW-1:0]      cur_ff, nxt_ff, adv_idx_ff, pend_idx_ff;
   logic               last_ff;
   logic [CELL_W-1:0]  dvd_ff, rem_ff, draw_ff, own_cell_ff;
   logic [3:0]         cnt_ff;
   logic [SPEED_W-1:0] own_speed_ff;
   logic [AW-1:0]      gap_ff;
   logic [COUNT_W-1:0] laps_ff;
   logic [TOTAL_W-1:0] total_ff;

   // Car store.
   logic [CELL_W-1:0]  cell_mem [MAX_CARS];
   logic [SPEED_W-1:0] speed_mem [MAX_CARS];
   logic [CELL_W-1:0]  cell_q_ff;
   logic [SPEED_W-1:0] speed_q_ff;

   // Combinational signals.
   logic [CELL_W-1:0]  len_w;
   logic [NW-1:0]      n_w;
   logic [CW-1:0]      cur_w, nxt_w;
   logic               cur_last_w, adv_last_w;
   logic               accept_w, emit_w, adv_proc_w;
   logic [CW-1:0]      rd_addr_w;
   logic [AW-1:0]      alu_a_w, alu_b_w, alu_sum_w;
   logic               alu_cin_w;
   logic [CELL_W:0]    rem_shift_w, move_sum_w;
   logic [AW-1:0]      gap_fix_w;
   logic [4:0]         gap_cap_w;
   logic [SPEED_W-1:0] v_acc_w, v_cap_w, v_new_w;
   logic [CELL_W-1:0]  moved_cell_w;
   logic               cell_we_w, speed_we_w;
   logic [CW-1:0]      cell_wa_w, speed_wa_w;
   logic [CELL_W-1:0]  cell_wd_w;
   logic [SPEED_W-1:0] speed_wd_w;

   // Effective track length and car count.
   assign len_w = (track_length_ff == '0) ? CELL_W'(1) : track_length_ff;
   assign n_w = (car_count_ff == '0) ? NW'(1) :
                ((32'(car_count_ff) > MAX_CARS) ? NW'(MAX_CARS) : NW'(car_count_ff));

   // Cursor, taken as zero when it lies beyond the car count, and its successor.
   assign cur_w      = (NW'(cursor_ff) >= n_w) ? '0 : cursor_ff;
   assign cur_last_w = (NW'(cur_w) + NW'(1) >= n_w);
   assign nxt_w      = cur_last_w ? '0 : cur_w + CW'(1);
   assign adv_last_w = (NW'(adv_idx_ff) + NW'(1) == n_w);

   assign accept_w   = req_valid && req_ready;
   assign emit_w     = (st_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign adv_proc_w = ((st_ff == ST_ADV) && pend_ff) || (st_ff == ST_ADV_DRAIN);

   // Shared adder.
   assign alu_sum_w = alu_a_w + alu_b_w + AW'(alu_cin_w);

   // Operand views for the remainder step and the move of one car.
   assign rem_shift_w = {rem_ff, dvd_ff[CELL_W-1]};
   assign move_sum_w  = {1'b0, cell_q_ff} + (CELL_W+1)'(speed_q_ff);
   assign moved_cell_w = alu_sum_w[AW-1] ? move_sum_w[CELL_W-1:0] : alu_sum_w[CELL_W-1:0];

   // Speed rule: accelerate, cap to the free gap, then random braking.
   assign gap_fix_w = gap_ff[AW-1] ? alu_sum_w : gap_ff;
   assign gap_cap_w = gap_fix_w[AW-1] ? 5'd0 :
                      ((|gap_fix_w[AW-2:5]) ? 5'd31 : gap_fix_w[4:0]);
   assign v_acc_w = (own_speed_ff < speed_limit_ff) ? own_speed_ff + SPEED_W'(1)
                                                    : own_speed_ff;
   assign v_cap_w = (v_acc_w > gap_cap_w) ? gap_cap_w : v_acc_w;
   assign v_new_w = ((v_cap_w != '0) && (draw_ff < brake_threshold_ff))
                    ? v_cap_w - SPEED_W'(1) : v_cap_w;

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept_w) begin
               st_in = (req_data.operation == OP_PLACE) ? ST_MOD : ST_DRAW_OWN;
            end
         end
         ST_MOD: begin
            if (cnt_ff == '0) begin
               st_in = ST_PLACE;
            end
         end
         ST_PLACE:     st_in = ST_IDLE;
         ST_DRAW_OWN:  st_in = ST_DRAW_GAP;
         ST_DRAW_GAP:  st_in = ST_DRAW_WRAP;
         ST_DRAW_WRAP: st_in = last_ff ? ST_ADV : ST_IDLE;
         ST_ADV: begin
            if (adv_last_w) begin
               st_in = ST_ADV_DRAIN;
            end
         end
         ST_ADV_DRAIN: st_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_w) begin
               st_in = ST_IDLE;
            end
         end
         default:      st_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, read address, adder operands, writes.
   always_comb begin
      req_ready  = 1'b0;
      rd_addr_w  = cur_w;
      alu_a_w    = '0;
      alu_b_w    = '0;
      alu_cin_w  = 1'b0;
      cell_we_w  = 1'b0;
      cell_wa_w  = cur_ff;
      cell_wd_w  = rem_ff;
      speed_we_w = 1'b0;
      speed_wa_w = cur_ff;
      speed_wd_w = '0;
      case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_MOD: begin
            alu_a_w   = AW'(rem_shift_w);
            alu_b_w   = ~AW'(len_w);
            alu_cin_w = 1'b1;
         end
         ST_PLACE: begin
            cell_we_w  = 1'b1;
            speed_we_w = 1'b1;
         end
         ST_DRAW_OWN: begin
            rd_addr_w = nxt_ff;
         end
         ST_DRAW_GAP: begin
            alu_a_w = AW'(cell_q_ff);
            alu_b_w = ~AW'(own_cell_ff);
         end
         ST_DRAW_WRAP: begin
            alu_a_w    = gap_ff;
            alu_b_w    = AW'(len_w);
            speed_we_w = 1'b1;
            speed_wd_w = v_new_w;
         end
         ST_ADV, ST_ADV_DRAIN: begin
            rd_addr_w = adv_idx_ff;
            alu_a_w   = AW'(move_sum_w);
            alu_b_w   = ~AW'(len_w);
            alu_cin_w = 1'b1;
            cell_we_w = adv_proc_w;
            cell_wa_w = pend_idx_ff;
            cell_wd_w = moved_cell_w;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Car store, one write and one registered read per array.
   always_ff @(posedge clock) begin
      if (cell_we_w) begin
         cell_mem[cell_wa_w] <= cell_wd_w;
      end
      cell_q_ff <= cell_mem[rd_addr_w];
   end

   always_ff @(posedge clock) begin
      if (speed_we_w) begin
         speed_mem[speed_wa_w] <= speed_wd_w;
      end
      speed_q_ff <= speed_mem[rd_addr_w];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         track_length_ff    <= TRACK_LENGTH_RST;
         speed_limit_ff     <= SPEED_LIMIT_RST;
         car_count_ff       <= CAR_COUNT_RST;
         brake_threshold_ff <= BRAKE_THRESHOLD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TRACK_LENGTH:    track_length_ff    <= csr_data;
            CSR_SPEED_LIMIT:     speed_limit_ff     <= csr_data[SPEED_W-1:0];
            CSR_CAR_COUNT:       car_count_ff       <= csr_data[COUNT_W-1:0];
            CSR_BRAKE_THRESHOLD: brake_threshold_ff <= csr_data;
            default:             track_length_ff    <= track_length_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cursor_ff    <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         st_ff <= st_in;
         if ((st_ff == ST_PLACE) || (st_ff == ST_DRAW_WRAP)) begin
            cursor_ff <= nxt_ff;
         end
         if (st_ff == ST_ADV) begin
            pend_ff <= 1'b1;
         end else begin
            pend_ff <= 1'b0;
         end
         if (emit_w) begin
            ticks_ff     <= ticks_ff + TICK_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      if (accept_w) begin
         cur_ff  <= cur_w;
         nxt_ff  <= nxt_w;
         last_ff <= cur_last_w;
         dvd_ff  <= req_data.cell_req;
         draw_ff <= req_data.draw;
         rem_ff  <= '0;
         cnt_ff  <= 4'd15;
      end
      // One restoring remainder step per cycle.
      if (st_ff == ST_MOD) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= alu_sum_w[AW-1] ? rem_shift_w[CELL_W-1:0] : alu_sum_w[CELL_W-1:0];
         cnt_ff <= cnt_ff - 4'd1;
      end
      if (st_ff == ST_DRAW_OWN) begin
         own_cell_ff  <= cell_q_ff;
         own_speed_ff <= speed_q_ff;
      end
      if (st_ff == ST_DRAW_GAP) begin
         gap_ff <= alu_sum_w;
      end
      // Move pass: clear the sums, then walk the cars.
      if (st_ff == ST_DRAW_WRAP) begin
         adv_idx_ff <= '0;
         laps_ff    <= '0;
         total_ff   <= '0;
      end
      if (st_ff == ST_ADV) begin
         pend_idx_ff <= adv_idx_ff;
         if (!adv_last_w) begin
            adv_idx_ff <= adv_idx_ff + CW'(1);
         end
      end
      if (adv_proc_w) begin
         laps_ff  <= laps_ff + COUNT_W'(!alu_sum_w[AW-1]);
         total_ff <= total_ff + TOTAL_W'(speed_q_ff);
      end
   end

   // Output register of the per-tick summary.
   always_ff @(posedge clock) begin
      if (emit_w) begin
         rsp_data_ff.tick_number <= ticks_ff + TICK_W'(1);
         rsp_data_ff.laps_done   <= laps_ff;
         rsp_data_ff.speed_total <= total_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// ----- hw/rtl/tca_checker.sv -----
`include "assert_macros.svh"

module tca_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input tca_pkg::req_type              req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input tca_pkg::rsp_type              rsp_data,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [tca_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [tca_pkg::CELL_W-1:0]    csr_data
);
   import tca_pkg::*;

   logic req_fire, rsp_fire;
   logic unused_ok;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign unused_ok = ^{req_data, csr_valid, csr_ready, csr_index, csr_data};

   // A stalled summary stays put.
   `TCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

   // Every accepted request makes the block busy before it can take another one.
   `TCA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_ready)

   // Summaries taken back to back count ticks one by one.
   `TCA_ASSERT_NEXT(a_tick_step, clock, reset, rsp_fire,
      !rsp_valid || (rsp_data.tick_number == 32'($past(rsp_data.tick_number) + 32'd1)))

   // A new summary rises only right after the block was busy.
   `TCA_ASSERT_IMP(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind traffic_cellular_automaton_step_top tca_checker u_tca_checker (.*);
